@@ hdl/stpd_pkg.sv @@
// Shared types and constants of the speed-timer packet decoder.
package stpd_pkg;

  // One input request: a received byte or a millisecond tick.
  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [1:0]  frame_status;
    logic        connected;
    logic [7:0]  timer_state;
    logic [19:0] total_ms;
    logic [31:0] interpolated_ms;
    logic [7:0]  shown_minutes;
    logic [5:0]  shown_seconds;
    logic [9:0]  shown_millis;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  idle_code;
    logic [7:0]  running_code;
    logic [7:0]  stopped_code;
    logic        normalize_enable;
  } cfg_t;

  // Frame status codes.
  localparam logic [1:0] FS_NONE     = 2'd0;
  localparam logic [1:0] FS_ACCEPTED = 2'd1;
  localparam logic [1:0] FS_BAD      = 2'd2;
  localparam logic [1:0] FS_SHORT    = 2'd3;

  // Register indexes (word address).
  localparam logic [2:0] REG_TIMEOUT   = 3'd0;
  localparam logic [2:0] REG_IDLE      = 3'd1;
  localparam logic [2:0] REG_RUNNING   = 3'd2;
  localparam logic [2:0] REG_STOPPED   = 3'd3;
  localparam logic [2:0] REG_NORMALIZE = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_TIMEOUT   = 16'd1000;
  localparam logic [7:0]  RST_IDLE      = 8'd73;
  localparam logic [7:0]  RST_RUNNING   = 8'd32;
  localparam logic [7:0]  RST_STOPPED   = 8'd83;
  localparam logic        RST_NORMALIZE = 1'b1;

  // Line framing.
  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [3:0] LINE_CAP   = 4'd8;
  localparam logic [7:0] CHECK_BASE = 8'd64;

  // Time units.
  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [9:0]  MS_PER_SEC = 10'd1000;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

endpackage

@@ hdl/speed_timer_packet_decoder_top.sv @@
// Top level of the speed-timer packet decoder.
//
// The input channel carries requests of two kinds: a received serial byte
// (action 0) or a one-millisecond tick (action 1). Bytes build a line that
// ends at carriage return; a full line is checked and, when valid, sets the
// held timer state, time and link. Every input request yields exactly one
// result request with the frame status, link flag, held state and time, the
// interpolated time and its split into minutes, seconds and milliseconds.
// Results pass s1_r to s5_r. One request is taken per cycle unless stalled,
// as each of the five pipeline stages passes one; the split stages each hold
// one multiplication by a constant. When the receiver stalls, the pipeline
// fills its empty stages and then raises in_stall; results already computed
// hold until taken. Reset clears the line length, timer state, tick counter,
// link flag and all pipeline valid bits, and loads the register defaults. The
// line store has no reset. The user must write configuration over the
// APB-style port only while idle; the block does not enforce it.
module speed_timer_packet_decoder_top import stpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t      cfg;
  logic      res_valid;
  logic      res_stall;
  out_item_t res_data;

  // Configuration registers.
  stpd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Line handling and timer state.
  stpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // Time split pipeline and output register.
  stpd_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (res_valid),
    .src_stall (res_stall),
    .src_data  (res_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/stpd_regs.sv @@
// APB-style configuration registers of the packet decoder.
module stpd_regs import stpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms       <= RST_TIMEOUT;
      cfg_r.idle_code        <= RST_IDLE;
      cfg_r.running_code     <= RST_RUNNING;
      cfg_r.stopped_code     <= RST_STOPPED;
      cfg_r.normalize_enable <= RST_NORMALIZE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TIMEOUT:   cfg_r.timeout_ms       <= cfg_pwdata[15:0];
        REG_IDLE:      cfg_r.idle_code        <= cfg_pwdata[7:0];
        REG_RUNNING:   cfg_r.running_code     <= cfg_pwdata[7:0];
        REG_STOPPED:   cfg_r.stopped_code     <= cfg_pwdata[7:0];
        REG_NORMALIZE: cfg_r.normalize_enable <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT:   cfg_prdata = {16'd0, cfg_r.timeout_ms};
      REG_IDLE:      cfg_prdata = {24'd0, cfg_r.idle_code};
      REG_RUNNING:   cfg_prdata = {24'd0, cfg_r.running_code};
      REG_STOPPED:   cfg_prdata = {24'd0, cfg_r.stopped_code};
      REG_NORMALIZE: cfg_prdata = {31'd0, cfg_r.normalize_enable};
      default:       cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/stpd_core.sv @@
// Line collection, packet parsing and timer state of the packet decoder.
module stpd_core import stpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_data
);

  logic [7:0]  line_r [8];
  logic [3:0]  len_r, len_nxt;
  logic [7:0]  held_state_r, held_state_nxt;
  logic [19:0] held_time_r, held_time_nxt;
  logic [31:0] ticks_r, ticks_nxt;
  logic        link_r, link_nxt;
  logic        v1_r;
  out_item_t   s1_r;

  logic        in_acc;
  logic        s1_adv;
  logic        store_we;
  logic [1:0]  status;
  logic [3:0]  dig [6];
  logic        digits_ok;
  logic [7:0]  sum;
  logic        parse_ok;
  logic [6:0]  secs;
  logic [9:0]  ms3;
  logic [19:0] total;
  logic [7:0]  new_state;
  logic        running;
  logic [31:0] interp;
  out_item_t   item;

  assign s1_adv    = !v1_r || !res_stall;
  assign in_stall  = !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign res_valid = v1_r;
  assign res_data  = s1_r;

  // Digit decode and checksum of a full line.
  always_comb begin
    digits_ok = 1'b1;
    sum       = CHECK_BASE;
    for (int i = 0; i < 6; i++) begin
      dig[i] = line_r[i+1][3:0];
      if (line_r[i+1][7:4] != 4'h3 || line_r[i+1][3:0] > 4'd9) digits_ok = 1'b0;
      sum = sum + {4'd0, line_r[i+1][3:0]};
    end
    parse_ok = digits_ok && (sum == line_r[7]);
  end

  // Total milliseconds and state normalization of the packet.
  always_comb begin
    secs  = 7'(dig[1]) * 7'd10 + 7'(dig[2]);
    ms3   = 10'(dig[3]) * 10'd100 + 10'(dig[4]) * 10'd10 + 10'(dig[5]);
    total = 20'(dig[0]) * 20'(MS_PER_MIN) + 20'(secs) * 20'(MS_PER_SEC) + 20'(ms3);
    new_state = line_r[0];
    if (cfg.normalize_enable && total != 20'd0 && line_r[0] == cfg.idle_code) begin
      new_state = cfg.stopped_code;
    end
  end

  // Next state for one request.
  always_comb begin
    len_nxt        = len_r;
    held_state_nxt = held_state_r;
    held_time_nxt  = held_time_r;
    ticks_nxt      = ticks_r;
    link_nxt       = link_r;
    store_we       = 1'b0;
    status         = FS_NONE;
    if (in_acc) begin
      if (in_data.action) begin
        if (ticks_r != 32'hFFFF_FFFF) ticks_nxt = ticks_r + 32'd1;
        if (ticks_nxt >= {16'd0, cfg.timeout_ms}) link_nxt = 1'b0;
      end else if (in_data.rx_byte == CR_BYTE) begin
        len_nxt = 4'd0;
        if (len_r >= LINE_CAP) begin
          if (parse_ok) begin
            status         = FS_ACCEPTED;
            held_state_nxt = new_state;
            held_time_nxt  = total;
            ticks_nxt      = 32'd0;
            link_nxt       = 1'b1;
          end else begin
            status = FS_BAD;
          end
        end else begin
          status = FS_SHORT;
        end
      end else if (len_r < LINE_CAP) begin
        store_we = 1'b1;
        len_nxt  = len_r + 4'd1;
      end
    end
  end

  // Result fields that follow directly from the updated state.
  always_comb begin
    running = (held_state_nxt == cfg.running_code);
    interp  = {12'd0, held_time_nxt} + (running ? ticks_nxt : 32'd0);
    item                 = '0;
    item.frame_status    = status;
    item.connected       = link_nxt;
    item.timer_state     = held_state_nxt;
    item.total_ms        = held_time_nxt;
    item.interpolated_ms = interp;
  end

  // Line store, written at the fill position.
  always_ff @(posedge clk) begin
    if (store_we) line_r[len_r[2:0]] <= in_data.rx_byte;
  end

  // Timer state and the first result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= 4'd0;
      held_state_r <= 8'd0;
      held_time_r  <= 20'd0;
      ticks_r      <= 32'd0;
      link_r       <= 1'b0;
      v1_r         <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      held_state_r <= held_state_nxt;
      held_time_r  <= held_time_nxt;
      ticks_r      <= ticks_nxt;
      link_r       <= link_nxt;
      if (s1_adv) v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_acc) s1_r <= item;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LINE_CAP) else $error("line length beyond capacity");

  a_accept_sets_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && status == FS_ACCEPTED |=> link_r && ticks_r == 32'd0)
    else $error("accepted packet did not restart the link");

  a_byte_keeps_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_data.action && in_data.rx_byte != CR_BYTE |=> $stable(ticks_r))
    else $error("data byte changed the tick counter");
`endif

endmodule

@@ hdl/stpd_split.sv @@
// Pipelined split of interpolated time into minutes, seconds and milliseconds.
module stpd_split import stpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      src_valid,
  output logic      src_stall,
  input  out_item_t src_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Reciprocals: x/60000 = (x>>5)/1875, r/1000 = (r>>3)/125.
  localparam int          MIN_SHIFT = 27;
  localparam logic [16:0] MIN_RECIP = 17'((64'd1 << MIN_SHIFT) / 64'd1875);
  localparam int          SEC_SHIFT = 16;
  localparam logic [9:0]  SEC_RECIP = 10'((64'd1 << SEC_SHIFT) / 64'd125);

  logic        v2_r, v3_r, v4_r, v5_r;
  logic        adv2, adv3, adv4, adv5;
  out_item_t   s2_r, s3_r, s4_r, s5_r;
  logic [16:0] q2_r, q3_r;
  logic [16:0] r3_r;
  logic [15:0] r4_r;
  logic [5:0]  sec4_r;

  logic [43:0] prod_min;
  logic [32:0] prod_q;
  logic [32:0] rem_full;
  logic        min_fix;
  logic [16:0] r_fix;
  logic [16:0] q_fix;
  logic [22:0] prod_sec;
  logic [15:0] prod_s;
  logic [15:0] rem_ms;
  logic        sec_fix;
  out_item_t   item4, item5;

  // Stage ready chain: a stage moves when empty or when its successor moves.
  assign adv5      = !v5_r || !out_stall;
  assign adv4      = !v4_r || adv5;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign src_stall = !adv2;
  assign out_valid = v5_r;
  assign out_data  = s5_r;

  // Stage 2: estimate of minutes, low by at most one.
  assign prod_min = {17'd0, src_data.interpolated_ms[31:5]} * {27'd0, MIN_RECIP};

  // Stage 3: remainder of the estimate.
  assign prod_q   = {16'd0, q2_r} * {17'd0, MS_PER_MIN};
  assign rem_full = {1'b0, s2_r.interpolated_ms} - prod_q;

  // Stage 4: correct minutes, estimate seconds.
  always_comb begin
    min_fix = (r3_r >= {1'b0, MS_PER_MIN});
    r_fix   = min_fix ? r3_r - {1'b0, MS_PER_MIN} : r3_r;
    q_fix   = q3_r + {16'd0, min_fix};
    prod_sec = {10'd0, r_fix[15:3]} * {13'd0, SEC_RECIP};
    item4 = s3_r;
    item4.shown_minutes = q_fix[7:0];
  end

  // Stage 5: correct seconds, milliseconds remainder.
  always_comb begin
    prod_s  = {10'd0, sec4_r} * {6'd0, MS_PER_SEC};
    rem_ms  = r4_r - prod_s;
    sec_fix = (rem_ms >= {6'd0, MS_PER_SEC});
    item5 = s4_r;
    item5.shown_seconds = sec4_r + {5'd0, sec_fix};
    item5.shown_millis  = sec_fix ? rem_ms[9:0] - MS_PER_SEC : rem_ms[9:0];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv2) v2_r <= src_valid;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv2 && src_valid) begin
      s2_r <= src_data;
      q2_r <= prod_min[43:MIN_SHIFT];
    end
    if (adv3 && v2_r) begin
      s3_r <= s2_r;
      q3_r <= q2_r;
      r3_r <= rem_full[16:0];
    end
    if (adv4 && v3_r) begin
      s4_r   <= item4;
      r4_r   <= r_fix[15:0];
      sec4_r <= prod_sec[SEC_SHIFT+5:SEC_SHIFT];
    end
    if (adv5 && v4_r) begin
      s5_r <= item5;
    end
  end

`ifndef SYNTHESIS
  a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.shown_seconds < SEC_PER_MIN)
    else $error("seconds out of range");

  a_millis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.shown_millis < MS_PER_SEC)
    else $error("milliseconds out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule
